FILE: hw/rtl/triangle_pixel_shade_macros.svh
// Assertion macros used by the checker of the triangle pixel shader.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef TRIANGLE_PIXEL_SHADE_MACROS_SVH
`define TRIANGLE_PIXEL_SHADE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("triangle_pixel_shade check failed");

// Next-cycle implication, checked outside reset.
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("triangle_pixel_shade check failed");

`endif

FILE: hw/rtl/tps_pkg.sv
// Shared constants and types of the triangle pixel shader.
// Used by the top level and its checker; depends on nothing.
package tps_pkg;

	localparam int FRAME_SIZE_DEF = 1024;
	localparam int IN_TDATA_W     = 24;
	localparam int OUT_TDATA_W    = 56;
	localparam int PIX_W          = 10;
	localparam int CENTER         = 4096;
	localparam logic [7:0] ALPHA  = 8'hFF;

	typedef enum logic [2:0] {
		REG_VERTEX_A = 3'd0,
		REG_VERTEX_B = 3'd1,
		REG_VERTEX_C = 3'd2,
		REG_COLOR_A  = 3'd3,
		REG_COLOR_B  = 3'd4,
		REG_COLOR_C  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             in_tri;
	} tag_t;

endpackage

FILE: hw/rtl/triangle_pixel_shade.sv
// Triangle pixel shader: edge-function inside test plus distance-weighted color blend.
// The distance square root takes one stage per root bit and the color divide one stage
// per quotient bit. Throughput is one pixel per clock while the output is not stalled.
// arst_n clears all valid bits and the triangle registers to zero.
// Depends on tps_pkg.
module triangle_pixel_shade #(
	parameter int FRAME_SIZE = tps_pkg::FRAME_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Pixel input beats. tdata: pixel_x [9:0], pixel_y [19:10], zero pad [23:20].
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tps_pkg::IN_TDATA_W-1:0]   s_tdata,
	// Result beats. tdata: out_x [9:0], out_y [19:10], pixel_argb [51:20], zero pad.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tps_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// tuser: inside_res [0].
	output logic                             m_tuser,
	// Triangle register writes.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [31:0]                      cfg_data
);

	// Pixel mapping: p = floor(pos*8192/FRAME_SIZE) - 4096. The quotient is taken with a
	// reciprocal multiply that may land one short, then fixed by one compare.
	localparam int PMAX  = (1023 * 8192) / FRAME_SIZE;
	localparam int QW    = $clog2(PMAX + 1);
	localparam int PW    = QW + 1;
	localparam int CW    = (PW > 17) ? PW : 17;
	localparam int DW    = CW + 1;
	localparam int NBW   = 2 * DW;
	localparam int SW    = DW + 2;
	localparam int NUMW  = SW + 10;
	localparam int QB    = 9;
	localparam int SQ0   = 5;
	localparam int SSUM  = SQ0 + DW + 1;
	localparam int SPROD = SSUM + 1;
	localparam int SNUM  = SPROD + 1;
	localparam int LAT   = SNUM + QB + 1;
	localparam logic [33:0] RECIP = 34'((2 ** 24) / FRAME_SIZE);

	// The whole pipeline moves together; it halts only when the output register holds a
	// beat that the sink does not take.
	logic adv;
	logic vld_s [1:LAT];
	tps_pkg::tag_t tag_s [1:LAT-1];

	assign adv       = !vld_s[LAT] || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_s[LAT];

	// Triangle registers.
	logic [31:0] vtx_q [3];
	logic [23:0] col_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vtx_q[i] <= '0;
				col_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (tps_pkg::reg_idx_t'(cfg_index))
				tps_pkg::REG_VERTEX_A: vtx_q[0] <= cfg_data;
				tps_pkg::REG_VERTEX_B: vtx_q[1] <= cfg_data;
				tps_pkg::REG_VERTEX_C: vtx_q[2] <= cfg_data;
				tps_pkg::REG_COLOR_A:  col_q[0] <= cfg_data[23:0];
				tps_pkg::REG_COLOR_B:  col_q[1] <= cfg_data[23:0];
				tps_pkg::REG_COLOR_C:  col_q[2] <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Vertex coordinates, with y negated as the triangle space expects.
	logic signed [CW-1:0] vx [3];
	logic signed [CW-1:0] vy [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = CW'($signed(vtx_q[i][31:16]));
			vy[i] = -CW'($signed(vtx_q[i][15:0]));
		end
	end

	// Valid chain and pixel tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	logic inside_c;

	// The inside flag joins the tag at the stage where the edge signs are known.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= '{x: s_tdata[9:0], y: s_tdata[19:10], in_tri: 1'b0};
			for (int k = 2; k < LAT; k++) begin
				if (k == SQ0) begin
					tag_s[k] <= '{x: tag_s[k-1].x, y: tag_s[k-1].y, in_tri: inside_c};
				end else begin
					tag_s[k] <= tag_s[k-1];
				end
			end
		end
	end

	// Stage 1: reciprocal multiply estimate of the quotient.
	logic [QW-1:0] qx_s1, qy_s1;
	logic [33:0]   prx, pry;

	assign prx = 34'(s_tdata[9:0]) * RECIP;
	assign pry = 34'(s_tdata[19:10]) * RECIP;

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1 <= QW'(prx >> 11);
			qy_s1 <= QW'(pry >> 11);
		end
	end

	// Stage 2: fix a short quotient by one, then center.
	logic signed [CW-1:0] px_s2, py_s2;
	logic [23:0] rx, ry;
	logic [QW-1:0] qxc, qyc;

	always_comb begin
		rx  = {1'b0, tag_s[1].x, 13'b0} - 24'(qx_s1) * 24'(FRAME_SIZE);
		ry  = {1'b0, tag_s[1].y, 13'b0} - 24'(qy_s1) * 24'(FRAME_SIZE);
		qxc = (rx >= 24'(FRAME_SIZE)) ? qx_s1 + QW'(1) : qx_s1;
		qyc = (ry >= 24'(FRAME_SIZE)) ? qy_s1 + QW'(1) : qy_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= $signed(CW'(qxc)) - CW'(tps_pkg::CENTER);
			py_s2 <= $signed(CW'(qyc)) - CW'(tps_pkg::CENTER);
		end
	end

	// Stage 3: differences to each vertex and the edge vectors.
	logic signed [DW-1:0] dpx_s3 [3], dpy_s3 [3], evx_s3 [3], evy_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dpx_s3[i] <= DW'(px_s2) - DW'(vx[i]);
				dpy_s3[i] <= DW'(py_s2) - DW'(vy[i]);
				evx_s3[i] <= DW'(vx[i]) - DW'(vx[(i+1)%3]);
				evy_s3[i] <= DW'(vy[i]) - DW'(vy[(i+1)%3]);
			end
		end
	end

	// Stage 4: edge products and squared distances.
	logic signed [NBW-1:0] pa_s4 [3], pb_s4 [3];
	logic [NBW-1:0] sqx_s4 [3], sqy_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				pa_s4[j]  <= dpx_s3[(j+1)%3] * evy_s3[j];
				pb_s4[j]  <= evx_s3[j] * dpy_s3[(j+1)%3];
				sqx_s4[j] <= NBW'(dpx_s3[j] * dpx_s3[j]);
				sqy_s4[j] <= NBW'(dpy_s3[j] * dpy_s3[j]);
			end
		end
	end

	// Stage 5: edge signs give the inside flag; squared distance sums seed the roots.
	logic signed [NBW:0] edge_v [3];
	logic any_neg, any_pos;

	always_comb begin
		any_neg = 1'b0;
		any_pos = 1'b0;
		for (int j = 0; j < 3; j++) begin
			edge_v[j] = (NBW+1)'(pa_s4[j]) - (NBW+1)'(pb_s4[j]);
			any_neg   = any_neg | edge_v[j][NBW];
			any_pos   = any_pos | (!edge_v[j][NBW] && (edge_v[j] != '0));
		end
		inside_c = !(any_neg && any_pos);
	end

	logic [NBW:0]  rt_rem_s  [0:DW][3];
	logic [DW-1:0] rt_root_s [0:DW][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				rt_rem_s[0][j]  <= (NBW+1)'(sqx_s4[j]) + (NBW+1)'(sqy_s4[j]);
				rt_root_s[0][j] <= '0;
			end
		end
	end

	// Square root, one root bit per stage, most significant first.
	for (genvar g = 0; g < DW; g++) begin : g_sqrt
		localparam int K = DW - 1 - g;
		logic [NBW:0] trial [3];

		always_comb begin
			for (int j = 0; j < 3; j++)
				trial[j] = ((NBW+1)'(rt_root_s[g][j]) << (K + 1))
					+ ((NBW+1)'(1) << (2 * K));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < 3; j++) begin
					if (rt_rem_s[g][j] >= trial[j]) begin
						rt_rem_s[g+1][j]  <= rt_rem_s[g][j] - trial[j];
						rt_root_s[g+1][j] <= rt_root_s[g][j] | (DW'(1) << K);
					end else begin
						rt_rem_s[g+1][j]  <= rt_rem_s[g][j];
						rt_root_s[g+1][j] <= rt_root_s[g][j];
					end
				end
			end
		end
	end

	// Distance sum.
	logic [SW-1:0] sum_s, sum_pr_s;
	logic [SW-1:0] dd_s [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s <= SW'(rt_root_s[DW][0]) + SW'(rt_root_s[DW][1]) + SW'(rt_root_s[DW][2]);
			for (int j = 0; j < 3; j++) dd_s[j] <= SW'(rt_root_s[DW][j]);
		end
	end

	// Weighted color products, per channel c and vertex j.
	logic [NUMW-1:0] pr_s [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_pr_s <= sum_s;
			for (int c = 0; c < 3; c++)
				for (int j = 0; j < 3; j++)
					pr_s[c][j] <= NUMW'(col_q[j][8*c +: 8]) * NUMW'(sum_s - dd_s[j]);
		end
	end

	// Numerators; they seed the divider.
	logic [NUMW-1:0] dv_rem_s [0:QB][3];
	logic [QB-1:0]   dv_q_s   [0:QB][3];
	logic [SW-1:0]   dv_den_s [0:QB];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_den_s[0] <= sum_pr_s;
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= pr_s[c][0] + pr_s[c][1] + pr_s[c][2];
				dv_q_s[0][c]   <= '0;
			end
		end
	end

	// Restoring divide, one quotient bit per stage; the quotient never reaches 512.
	for (genvar g = 0; g < QB; g++) begin : g_div
		localparam int K = QB - 1 - g;
		logic [NUMW-1:0] den_sh;

		assign den_sh = NUMW'(dv_den_s[g]) << K;

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_den_s[g+1] <= dv_den_s[g];
				for (int c = 0; c < 3; c++) begin
					if (dv_rem_s[g][c] >= den_sh) begin
						dv_rem_s[g+1][c] <= dv_rem_s[g][c] - den_sh;
						dv_q_s[g+1][c]   <= dv_q_s[g][c] | (QB'(1) << K);
					end else begin
						dv_rem_s[g+1][c] <= dv_rem_s[g][c];
						dv_q_s[g+1][c]   <= dv_q_s[g][c];
					end
				end
			end
		end
	end

	// Output register: saturate, vertex A's color on a zero distance sum, 0 outside, pack.
	logic [7:0] chan [3];
	logic [31:0] argb;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dv_den_s[QB] == '0)
				chan[c] = col_q[0][8*c +: 8];
			else if (dv_q_s[QB][c] > QB'(255))
				chan[c] = 8'hFF;
			else
				chan[c] = dv_q_s[QB][c][7:0];
		end
		argb = tag_s[LAT-1].in_tri ? {tps_pkg::ALPHA, chan[2], chan[1], chan[0]} : 32'h0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {4'b0, argb, tag_s[LAT-1].y, tag_s[LAT-1].x};
			m_tuser <= tag_s[LAT-1].in_tri;
		end
	end

endmodule

FILE: hw/rtl/tps_checker.sv
// Port-level checker for the triangle pixel shader, bound to the top level.
// Depends on tps_pkg and triangle_pixel_shade_macros.svh.
`include "triangle_pixel_shade_macros.svh"

module tps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tps_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	// A pixel outside the triangle carries a zero color word.
	`TPS_ASSERT_NOW(a_outside_black, m_tvalid && !m_tuser, m_tdata[51:20] == 32'h0)

	// A pixel inside the triangle is fully opaque.
	`TPS_ASSERT_NOW(a_inside_opaque, m_tvalid && m_tuser, m_tdata[51:44] == tps_pkg::ALPHA)

	// With the output register empty the pipeline can always take a pixel.
	`TPS_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

	// A stalled result beat holds.
	`TPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind triangle_pixel_shade tps_checker u_tps_checker (.*);
